// File: src/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator; depends on nothing.
package ffba_pkg;

  localparam int KIND_W     = 2;
  localparam int REQ_W      = 9;
  localparam int PID_W      = 8;
  localparam int UADDR_W    = 8;
  localparam int BASE_W     = 8;
  localparam int OWN_W      = 8;
  localparam int TOT_W      = 9;
  localparam int MAX_IDX_W  = 8;
  localparam int MAX_SIZE_W = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_SET_USED = 3'd1,
    CMD_SPLIT    = 3'd2,
    CMD_RELEASE  = 3'd3,
    CMD_MERGE    = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e                  op;
    logic [MAX_IDX_W-1:0]  idx;
    logic [MAX_SIZE_W-1:0] size;
    logic [OWN_W-1:0]      id;
  } cell_cmd_t;

endpackage

// File: src/ffba_cell.sv
// One table slot of the allocator: size, owner and used flag of one block.
// Acts on the broadcast command and trades entries with its neighbors.
// Depends on ffba_pkg.
module ffba_cell #(
  parameter int CELL_IDX   = 0,
  parameter int SIZE_W     = 9,
  parameter int RESET_SIZE = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ffba_pkg::cell_cmd_t               cmd_i,
  input  logic [SIZE_W-1:0]                 prev_size_i,
  input  logic [ffba_pkg::OWN_W-1:0]        prev_owner_i,
  input  logic                              prev_used_i,
  input  logic [SIZE_W-1:0]                 next_size_i,
  input  logic [ffba_pkg::OWN_W-1:0]        next_owner_i,
  input  logic                              next_used_i,
  output logic [SIZE_W-1:0]                 size_o,
  output logic [ffba_pkg::OWN_W-1:0]        owner_o,
  output logic                              used_o
);
  import ffba_pkg::*;

  localparam logic [MAX_IDX_W:0] MyIdx = (MAX_IDX_W+1)'(CELL_IDX);

  logic [SIZE_W-1:0] size_q, size_d;
  logic [OWN_W-1:0]  owner_q, owner_d;
  logic              used_q, used_d;
  logic [MAX_IDX_W:0] sel;
  logic              is_me, is_next, above;

  assign sel     = {1'b0, cmd_i.idx};
  assign is_me   = (sel == MyIdx);
  assign is_next = ((sel + (MAX_IDX_W+1)'(1)) == MyIdx);
  assign above   = (MyIdx > sel);

  always_comb begin
    size_d  = size_q;
    owner_d = owner_q;
    used_d  = used_q;
    case (cmd_i.op)
      CMD_SET_USED: begin
        if (is_me) begin
          used_d  = 1'b1;
          owner_d = cmd_i.id;
        end
      end
      CMD_SPLIT: begin
        if (is_me) begin
          size_d = size_q - SIZE_W'(cmd_i.size);
        end else if (is_next) begin
          size_d  = SIZE_W'(cmd_i.size);
          owner_d = cmd_i.id;
          used_d  = 1'b1;
        end else if (above) begin
          // open a slot: take the left neighbor
          size_d  = prev_size_i;
          owner_d = prev_owner_i;
          used_d  = prev_used_i;
        end
      end
      CMD_RELEASE: begin
        if (used_q && owner_q == cmd_i.id) begin
          used_d  = 1'b0;
          owner_d = '0;
        end
      end
      CMD_MERGE: begin
        if (is_me) begin
          size_d = size_q + next_size_i;
        end else if (above) begin
          // close the gap: take the right neighbor
          size_d  = next_size_i;
          owner_d = next_owner_i;
          used_d  = next_used_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_W'(RESET_SIZE);
      owner_q <= '0;
      used_q  <= 1'b0;
    end else begin
      size_q  <= size_d;
      owner_q <= owner_d;
      used_q  <= used_d;
    end
  end

  assign size_o  = size_q;
  assign owner_o = owner_q;
  assign used_o  = used_q;

endmodule

// File: src/first_fit_block_allocator.sv
// First-fit block allocator: top level with the sequencer and the cell row.
// Depends on ffba_pkg and ffba_cell.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one request beat:
//   allocate, free by id, or read the owner of one unit. The output channel
//   (out_valid_o / out_stall_i) returns one result beat per request with the
//   status, base address, owner and the free totals after the request.
//   The block table lives in a row of MAX_BLOCKS cells; splits and merges move
//   entries one slot between neighbors, all cells together. A request is
//   dispatched, then walks the table one entry at a time (allocate and read
//   stop at the first fitting or covering block; free releases every block of
//   the id, then a merge walk either advances or folds one block per step),
//   then a statistics walk over all blocks, then the output register is
//   loaded. The table walks go through the single read port of the cell row.
//   One request is worked on at a time; the next is taken as soon as the
//   result sits in the output register, even while the receiver stalls it.
//   Reset leaves one free block covering all of memory and no result pending.
//   A stalled result holds its beat unchanged until taken.
module first_fit_block_allocator #(
  parameter int MEM_UNITS  = 256,
  parameter int MAX_BLOCKS = 32,
  parameter int ID_BITS    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ffba_pkg::KIND_W-1:0]      kind_i,
  input  logic [ffba_pkg::REQ_W-1:0]       request_size_i,
  input  logic [ffba_pkg::PID_W-1:0]       process_id_i,
  input  logic [ffba_pkg::UADDR_W-1:0]     unit_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [ffba_pkg::BASE_W-1:0]      base_address_o,
  output logic [ffba_pkg::OWN_W-1:0]       owner_id_o,
  output logic [ffba_pkg::TOT_W-1:0]       free_total_o,
  output logic [ffba_pkg::TOT_W-1:0]       largest_free_o
);
  import ffba_pkg::*;

  localparam int SIZE_W  = $clog2(MEM_UNITS + 1);
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int CW      = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
  localparam int ID_KEEP = (ID_BITS < OWN_W) ? ID_BITS : OWN_W;
  localparam logic [OWN_W-1:0] ID_MASK = OWN_W'((1 << ID_KEEP) - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ALLOC = 7'b0000010,
    S_FREE  = 7'b0000100,
    S_MERGE = 7'b0001000,
    S_READ  = 7'b0010000,
    S_STAT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]     req_q, req_d;
  logic [OWN_W-1:0]  id_q, id_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] pos_q, pos_d;
  logic              prev_free_q, prev_free_d;
  logic [CNT_W-1:0]  block_count_q, block_count_d;
  logic              res_ok_q, res_ok_d;
  logic [BASE_W-1:0] res_base_q, res_base_d;
  logic [OWN_W-1:0]  res_owner_q, res_owner_d;
  logic [SIZE_W-1:0] tot_q, tot_d;
  logic [SIZE_W-1:0] big_q, big_d;

  logic              out_valid_q;
  logic              ok_q;
  logic [BASE_W-1:0] base_q;
  logic [OWN_W-1:0]  owner_q;
  logic [TOT_W-1:0]  free_total_q, largest_free_q;

  cell_cmd_t cmd;

  logic [SIZE_W-1:0] cell_size  [MAX_BLOCKS];
  logic [OWN_W-1:0]  cell_owner [MAX_BLOCKS];
  logic              cell_used  [MAX_BLOCKS];

  logic [SIZE_W-1:0] cur_size;
  logic [OWN_W-1:0]  cur_owner;
  logic              cur_used;
  logic              in_range;
  logic              hit;
  logic              accept;
  logic              load_out;
  logic [OWN_W-1:0]  in_id;

  // Cell row: each slot trades entries with its neighbors.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    logic [SIZE_W-1:0] p_size, n_size;
    logic [OWN_W-1:0]  p_owner, n_owner;
    logic              p_used, n_used;

    if (g == 0) begin : g_first
      assign p_size  = '0;
      assign p_owner = '0;
      assign p_used  = 1'b0;
    end else begin : g_mid_prev
      assign p_size  = cell_size[g-1];
      assign p_owner = cell_owner[g-1];
      assign p_used  = cell_used[g-1];
    end

    if (g == MAX_BLOCKS - 1) begin : g_last
      assign n_size  = '0;
      assign n_owner = '0;
      assign n_used  = 1'b0;
    end else begin : g_mid_next
      assign n_size  = cell_size[g+1];
      assign n_owner = cell_owner[g+1];
      assign n_used  = cell_used[g+1];
    end

    ffba_cell #(
      .CELL_IDX   (g),
      .SIZE_W     (SIZE_W),
      .RESET_SIZE ((g == 0) ? MEM_UNITS : 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_size_i  (p_size),
      .prev_owner_i (p_owner),
      .prev_used_i  (p_used),
      .next_size_i  (n_size),
      .next_owner_i (n_owner),
      .next_used_i  (n_used),
      .size_o       (cell_size[g]),
      .owner_o      (cell_owner[g]),
      .used_o       (cell_used[g])
    );
  end

  // Single read port into the row at the walk index.
  assign in_range  = (idx_q < block_count_q);
  assign cur_size  = cell_size[idx_q[IDX_W-1:0]];
  assign cur_owner = cell_owner[idx_q[IDX_W-1:0]];
  assign cur_used  = cell_used[idx_q[IDX_W-1:0]];

  // Does the freed id own any block at all?
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (cell_used[k] && cell_owner[k] == id_q) begin
        hit = 1'b1;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_id      = process_id_i & ID_MASK;
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    id_d          = id_q;
    addr_d        = addr_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    prev_free_d   = prev_free_q;
    block_count_d = block_count_q;
    res_ok_d      = res_ok_q;
    res_base_d    = res_base_q;
    res_owner_d   = res_owner_q;
    tot_d         = tot_q;
    big_d         = big_q;
    cmd.op        = CMD_NONE;
    cmd.idx       = MAX_IDX_W'(idx_q);
    cmd.size      = MAX_SIZE_W'(req_q);
    cmd.id        = id_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d       = CW'(request_size_i);
          id_d        = in_id;
          addr_d      = CW'(unit_address_i);
          idx_d       = '0;
          pos_d       = '0;
          prev_free_d = 1'b0;
          res_ok_d    = 1'b0;
          res_base_d  = '0;
          res_owner_d = '0;
          tot_d       = '0;
          big_d       = '0;
          state_d     = S_STAT;
          case (kind_e'(kind_i))
            KIND_ALLOC: begin
              if (request_size_i != '0 && in_id != '0) state_d = S_ALLOC;
            end
            KIND_FREE: begin
              if (in_id != '0) state_d = S_FREE;
            end
            KIND_READ: begin
              if (CW'(unit_address_i) < CW'(MEM_UNITS)) state_d = S_READ;
            end
            default: ;
          endcase
        end
      end

      S_ALLOC: begin
        if (!in_range) begin
          idx_d   = '0;
          state_d = S_STAT;
        end else if (!cur_used && CW'(cur_size) >= req_q) begin
          idx_d   = '0;
          state_d = S_STAT;
          if (CW'(cur_size) == req_q) begin
            cmd.op     = CMD_SET_USED;
            res_ok_d   = 1'b1;
            res_base_d = BASE_W'(pos_q);
          end else if (block_count_q < CNT_W'(MAX_BLOCKS)) begin
            // shrink the free block, place the new one at its high end
            cmd.op        = CMD_SPLIT;
            block_count_d = block_count_q + CNT_W'(1);
            res_ok_d      = 1'b1;
            res_base_d    = BASE_W'(pos_q + cur_size - SIZE_W'(req_q));
          end
        end else begin
          pos_d = pos_q + cur_size;
          idx_d = idx_q + CNT_W'(1);
        end
      end

      S_FREE: begin
        idx_d       = '0;
        prev_free_d = 1'b0;
        if (hit) begin
          cmd.op   = CMD_RELEASE;
          res_ok_d = 1'b1;
          state_d  = S_MERGE;
        end else begin
          state_d = S_STAT;
        end
      end

      S_MERGE: begin
        if (!in_range) begin
          idx_d   = '0;
          state_d = S_STAT;
        end else if (prev_free_q && !cur_used) begin
          // fold this block into its free left neighbor, hold the index
          cmd.op        = CMD_MERGE;
          cmd.idx       = MAX_IDX_W'(idx_q - CNT_W'(1));
          block_count_d = block_count_q - CNT_W'(1);
        end else begin
          prev_free_d = !cur_used;
          idx_d       = idx_q + CNT_W'(1);
        end
      end

      S_READ: begin
        if (!in_range) begin
          idx_d   = '0;
          state_d = S_STAT;
        end else if (addr_q < CW'(pos_q + cur_size)) begin
          res_ok_d    = 1'b1;
          res_owner_d = cur_used ? cur_owner : '0;
          idx_d       = '0;
          state_d     = S_STAT;
        end else begin
          pos_d = pos_q + cur_size;
          idx_d = idx_q + CNT_W'(1);
        end
      end

      S_STAT: begin
        if (!in_range) begin
          state_d = S_OUT;
        end else begin
          if (!cur_used) begin
            tot_d = tot_q + cur_size;
            if (cur_size > big_q) big_d = cur_size;
          end
          idx_d = idx_q + CNT_W'(1);
        end
      end

      S_OUT: begin
        if (load_out) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      prev_free_q   <= 1'b0;
      block_count_q <= CNT_W'(1);
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      prev_free_q   <= prev_free_d;
      block_count_q <= block_count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    id_q        <= id_d;
    addr_q      <= addr_d;
    pos_q       <= pos_d;
    res_ok_q    <= res_ok_d;
    res_base_q  <= res_base_d;
    res_owner_q <= res_owner_d;
    tot_q       <= tot_d;
    big_q       <= big_d;
    if (load_out) begin
      ok_q           <= res_ok_q;
      base_q         <= res_base_q;
      owner_q        <= res_owner_q;
      free_total_q   <= TOT_W'(tot_q);
      largest_free_q <= TOT_W'(big_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign base_address_o = base_q;
  assign owner_id_o     = owner_q;
  assign free_total_o   = free_total_q;
  assign largest_free_o = largest_free_q;

  // The table never empties and never outgrows the cell row.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_count_q != '0 && block_count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count out of range");

  // A split needs a spare cell.
  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == CMD_SPLIT |-> block_count_q < CNT_W'(MAX_BLOCKS))
    else $error("split with a full table");

  // An accepted request always leaves idle on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("request accepted without work");

  // The largest free block never exceeds the free total.
  a_largest_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> largest_free_q <= free_total_q)
    else $error("largest free block above free total");

endmodule
